// File: design/cfr_pkg.sv
package cfr_pkg;

  // Default number of digit bytes carried by one frame.
  localparam int DEF_DIGIT_COUNT = 27;

  // Frame layout and header codes.
  localparam logic [7:0] SYNC_A     = 8'hA5;
  localparam logic [7:0] SYNC_B     = 8'h5A;
  localparam logic [7:0] TYPE_STATE = 8'h01;

  localparam int OFS_SYNC_A = 0;
  localparam int OFS_SYNC_B = 1;
  localparam int OFS_TYPE   = 2;
  localparam int OFS_LEN    = 4;
  localparam int OFS_CTRL   = 6;
  localparam int DIGIT_BASE = 7;

  // The frame is the digit field plus sixteen bytes of header, mask and checksum.
  localparam int FRAME_EXTRA   = 16;
  localparam int PAYLOAD_EXTRA = 10;
  localparam int MASK_BYTES    = 8;

  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 5;
  localparam int BRIGHT_W = 4;
  localparam int MASK_W  = 64;

  // Controls for one cell of the result buffer.
  typedef struct packed {
    logic load;
    logic shift;
  } out_cell_ctrl_t;

endpackage

// File: design/cfr_win_cell.sv
module cfr_win_cell (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       shift_en,
  input  logic [7:0] d_in,
  output logic [7:0] q
);
  import cfr_pkg::*;

  logic [BYTE_W-1:0] byte_r;
  logic [BYTE_W-1:0] byte_nxt;

  // Cleared at reset so the running checksum built on these cells starts defined.
  always_comb begin
    byte_nxt = shift_en ? d_in : byte_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  assign q = byte_r;

endmodule

// File: design/cfr_out_cell.sv
module cfr_out_cell (
  input  logic                    clk,
  input  cfr_pkg::out_cell_ctrl_t ctrl,
  input  logic [7:0]              load_val,
  input  logic [7:0]              shift_in,
  output logic [7:0]              q
);
  import cfr_pkg::*;

  logic [BYTE_W-1:0] digit_r;
  logic [BYTE_W-1:0] digit_nxt;

  // A new frame takes precedence over moving the queue along.
  always_comb begin
    priority if (ctrl.load) begin
      digit_nxt = load_val;
    end else if (ctrl.shift) begin
      digit_nxt = shift_in;
    end else begin
      digit_nxt = digit_r;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign q = digit_r;

endmodule

// File: design/checksummed_frame_receiver.sv
// Channel   Direction  Ports                                   Transaction
// -------   ---------  --------------------------------------  ---------------------------
// in_       input      in_valid, in_ready, in_rx_byte          one received byte
// out_      output     out_valid, out_ready, out_digit_index,  one digit of an accepted
//                      out_digit_value, out_all_on,            frame, with the frame's
//                      out_brightness, out_symbol_mask,        control and mask fields
//                      out_last
//
// One byte is taken each cycle that in_ready is high; each byte shifts the window
// of cells by one place. An accepted frame is detected in the cycle after its last
// byte, then drains one digit per cycle with out_ready high from a second row of cells.
// Reset is synchronous and active low; it empties the window and the result buffer.
// in_ready drops only when a complete frame sits in the window while the result
// buffer still holds digits of the previous frame that out_ready has not taken.
module checksummed_frame_receiver #(
  parameter int DIGIT_COUNT = cfr_pkg::DEF_DIGIT_COUNT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_digit_index,
  output logic [7:0]  out_digit_value,
  output logic        out_all_on,
  output logic [3:0]  out_brightness,
  output logic [63:0] out_symbol_mask,
  output logic        out_last
);
  import cfr_pkg::*;

  localparam int FRAME_LEN   = DIGIT_COUNT + FRAME_EXTRA;
  localparam int LEN_CODE    = DIGIT_COUNT + PAYLOAD_EXTRA;
  localparam int SYM_BASE    = DIGIT_BASE + DIGIT_COUNT;
  localparam int FILL_W      = $clog2(FRAME_LEN + 1);
  localparam int IDX_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  // Window of cells: offset 0 holds the oldest byte, the newest enters at the top.
  logic [BYTE_W-1:0] win_q [FRAME_LEN];
  logic [BYTE_W-1:0] dig_q [DIGIT_COUNT];

  logic              in_fire;
  logic              out_fire;
  logic              frame_hit;
  logic              buf_free;
  logic              load_frame;
  out_cell_ctrl_t    out_ctrl;

  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic [BYTE_W-1:0] sum_r;
  logic [BYTE_W-1:0] sum_nxt;
  logic              busy_r;
  logic              busy_nxt;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  idx_nxt;
  logic              all_on_r;
  logic [BRIGHT_W-1:0] bright_r;
  logic [MASK_W-1:0] mask_r;
  logic [MASK_W-1:0] mask_cap;
  logic              idx_last;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  genvar gi;
  generate
    for (gi = 0; gi < FRAME_LEN; gi++) begin : g_win
      if (gi == FRAME_LEN - 1) begin : g_top
        cfr_win_cell u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .shift_en (in_fire),
          .d_in     (in_rx_byte),
          .q        (win_q[gi])
        );
      end else begin : g_mid
        cfr_win_cell u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .shift_en (in_fire),
          .d_in     (win_q[gi+1]),
          .q        (win_q[gi])
        );
      end
    end
  endgenerate

  // Running checksum over offsets 2 through FRAME_LEN-2. On a shift the byte at
  // offset 2 leaves the range and the byte now at the top moves into it.
  always_comb begin
    sum_nxt = sum_r;
    if (in_fire) begin
      sum_nxt = sum_r - win_q[OFS_TYPE] + win_q[FRAME_LEN-1];
    end
  end

  // The window is tested on registered contents, in the cycle after its last byte.
  assign frame_hit = (fill_r == FILL_W'(FRAME_LEN))
                  && (win_q[OFS_SYNC_A] == SYNC_A)
                  && (win_q[OFS_SYNC_B] == SYNC_B)
                  && (win_q[OFS_TYPE] == TYPE_STATE)
                  && (win_q[OFS_LEN] == BYTE_W'(LEN_CODE))
                  && (sum_r == win_q[FRAME_LEN-1]);

  // The buffer can take a new frame when empty or when its final digit leaves now.
  assign idx_last   = (idx_r == IDX_W'(DIGIT_COUNT - 1));
  assign buf_free   = !busy_r || (out_ready && idx_last);
  assign load_frame = frame_hit && buf_free;

  // A full matching window must not slide before the buffer has room for it.
  assign in_ready = !frame_hit || buf_free;

  // Fill count of bytes since the last accepted frame; a frame consumes the window.
  always_comb begin
    fill_nxt = fill_r;
    if (load_frame) begin
      fill_nxt = in_fire ? FILL_W'(1) : '0;
    end else if (in_fire && (fill_r != FILL_W'(FRAME_LEN))) begin
      fill_nxt = fill_r + FILL_W'(1);
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    priority if (load_frame) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (out_fire) begin
      if (idx_last) begin
        busy_nxt = 1'b0;
      end
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      sum_r  <= '0;
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      sum_r  <= sum_nxt;
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  // Symbol mask: eight bytes after the digit field, first byte in the low bits.
  always_comb begin
    for (int k = 0; k < MASK_BYTES; k++) begin
      mask_cap[k*BYTE_W +: BYTE_W] = win_q[SYM_BASE + k];
    end
  end

  always_ff @(posedge clk) begin
    if (load_frame) begin
      all_on_r <= win_q[OFS_CTRL][0];
      bright_r <= win_q[OFS_CTRL][BYTE_W-1 -: BRIGHT_W];
      mask_r   <= mask_cap;
    end
  end

  // Result buffer: a row of cells loaded in parallel from the digit field and
  // drained toward cell 0, which drives the output.
  assign out_ctrl.load  = load_frame;
  assign out_ctrl.shift = out_fire;

  generate
    for (gi = 0; gi < DIGIT_COUNT; gi++) begin : g_dig
      if (gi == DIGIT_COUNT - 1) begin : g_top
        cfr_out_cell u_cell (
          .clk      (clk),
          .ctrl     (out_ctrl),
          .load_val (win_q[DIGIT_BASE + gi]),
          .shift_in (dig_q[gi]),
          .q        (dig_q[gi])
        );
      end else begin : g_mid
        cfr_out_cell u_cell (
          .clk      (clk),
          .ctrl     (out_ctrl),
          .load_val (win_q[DIGIT_BASE + gi]),
          .shift_in (dig_q[gi+1]),
          .q        (dig_q[gi])
        );
      end
    end
  endgenerate

  assign out_valid       = busy_r;
  assign out_digit_index = INDEX_W'(idx_r);
  assign out_digit_value = dig_q[0];
  assign out_all_on      = all_on_r;
  assign out_brightness  = bright_r;
  assign out_symbol_mask = mask_r;
  assign out_last        = idx_last;

  // Input only stalls behind a result buffer that is still draining.
  a_stall_needs_busy : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with an empty result buffer");

  // A loaded frame starts at digit zero.
  a_load_starts_at_zero : assert property (@(posedge clk) disable iff (!rst_n)
    load_frame |=> (out_valid && (idx_r == '0)))
    else $error("frame load did not restart the digit index");

  // Acceptance consumes the window.
  a_load_consumes : assert property (@(posedge clk) disable iff (!rst_n)
    load_frame |=> (fill_r <= FILL_W'(1)))
    else $error("window not consumed after an accepted frame");

  // The fill count never passes the frame length.
  a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(FRAME_LEN))
    else $error("fill count beyond frame length");

endmodule
